FILE: hw/rtl/polycen_pkg.sv
`default_nettype none

package polycen_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_AREA = 2'd1,
    ST_TOO_MANY  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_CROSS,
    S_MOMX,
    S_MOMY,
    S_ACCY,
    S_FIN,
    S_DIV,
    S_SAT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/polygon_centroid.sv
`default_nettype none

// channel  direction  handshake          payload
// in_      sink       in_valid/in_stall   vertex_x, vertex_y, last_vertex
// out_     source     out_valid/out_stall centroid_x, centroid_y, status
//
// One multiplier, registered, serves both cross products and both moment terms of each edge:
// a vertex that adds an edge runs S_MUL0, S_MUL1, S_CROSS, S_MOMX, S_MOMY, S_ACCY; the first
// vertex of a polygon, unless also the last, is only stored. A last vertex adds the closing
// edge through the same states, then S_FIN checks, and a restoring divider, one bit a cycle,
// runs twice. Reset clears the sequencer, the sums and the vertex count. in_stall is high
// while an item is in work; the next polygon may start while a result waits under out_stall.

module polygon_centroid #(
  parameter int COORD_WIDTH  = 16,
  parameter int MAX_VERTICES = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [COORD_WIDTH-1:0] in_vertex_x,
  input  wire logic [COORD_WIDTH-1:0] in_vertex_y,
  input  wire logic                   in_last_vertex,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [COORD_WIDTH-1:0]      out_centroid_x,
  output logic [COORD_WIDTH-1:0]      out_centroid_y,
  output logic [1:0]                  out_status
);

  localparam int CW    = COORD_WIDTH;
  localparam int LOG_V = $clog2(MAX_VERTICES);
  localparam int XW    = 2 * CW + 1;           // cross product
  localparam int PW    = 3 * CW + 2;           // multiplier product
  localparam int DW    = XW + LOG_V;           // doubled area sum
  localparam int MW    = PW + LOG_V;           // moment sums
  localparam int DDW   = DW + 2;               // 3 * doubled area
  localparam int CNTW  = $clog2(MAX_VERTICES + 1);
  localparam int DCW   = $clog2(MW);

  localparam logic [CNTW-1:0] VMAX     = CNTW'(MAX_VERTICES);
  localparam logic [MW-1:0]   QMAX     = MW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [MW-1:0]   QMIN_MAG = MW'(64'd1 << (CW - 1));
  localparam logic [DCW-1:0]  DIV_LAST = DCW'(MW - 1);

  polycen_pkg::state_t  state_r, state_nxt;
  polycen_pkg::status_t st_r;

  logic [CW-1:0]   first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [CW-1:0]   ex0_r, ey0_r, ex1_r, ey1_r;
  logic [DW-1:0]   d_r;
  logic [MW-1:0]   mx_r, my_r;
  logic [CNTW-1:0] count_r;
  logic            ovf_r, last_r, close_r, sel_y_r;
  logic [PW-1:0]   prod_r, pa_r;
  logic [XW-1:0]   cross_r;

  logic [DDW-1:0]  rem_r, da_r;
  logic [MW-1:0]   nq_r;
  logic            nn_r, dn_r;
  logic [DCW-1:0]  cnt_r;
  logic [CW-1:0]   cx_r, cy_r;

  logic            out_valid_r;
  logic [CW-1:0]   out_cx_r, out_cy_r;
  logic [1:0]      out_st_r;

  logic            acc, full, out_free;
  logic [CW:0]     mul_a;
  logic [XW-1:0]   mul_b;
  logic [PW-1:0]   prod_w;
  logic [XW-1:0]   cross_w;
  logic [DDW-1:0]  den_w, da_w;
  logic [MW-1:0]   mx_mag, my_mag;
  logic [DDW:0]    rem_sh;
  logic            q_bit;
  logic [DDW-1:0]  rem_nxt;
  logic            q_neg;
  logic [MW-1:0]   q_clip, q_negv;
  logic [CW-1:0]   res_w;

  assign acc      = in_valid && (state_r == polycen_pkg::S_IDLE);
  assign full     = (count_r >= VMAX);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != polycen_pkg::S_IDLE);

  assign out_valid      = out_valid_r;
  assign out_centroid_x = out_cx_r;
  assign out_centroid_y = out_cy_r;
  assign out_status     = out_st_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      polycen_pkg::S_MUL0: begin
        mul_a = {ex0_r[CW-1], ex0_r};
        mul_b = {{(XW-CW){ey1_r[CW-1]}}, ey1_r};
      end
      polycen_pkg::S_MUL1: begin
        mul_a = {ex1_r[CW-1], ex1_r};
        mul_b = {{(XW-CW){ey0_r[CW-1]}}, ey0_r};
      end
      polycen_pkg::S_MOMX: begin
        mul_a = {ex0_r[CW-1], ex0_r} + {ex1_r[CW-1], ex1_r};
        mul_b = cross_r;
      end
      polycen_pkg::S_MOMY: begin
        mul_a = {ey0_r[CW-1], ey0_r} + {ey1_r[CW-1], ey1_r};
        mul_b = cross_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_w = $signed(mul_a) * $signed(mul_b);

  logic [PW-1:0] cross_full;
  assign cross_full = pa_r - prod_r;
  assign cross_w    = cross_full[XW-1:0];

  // 3 * D and magnitudes for the divider
  assign den_w  = {{2{d_r[DW-1]}}, d_r} + {d_r[DW-1], d_r, 1'b0};
  assign da_w   = den_w[DDW-1] ? (~den_w + 1'b1) : den_w;
  assign mx_mag = mx_r[MW-1] ? (~mx_r + 1'b1) : mx_r;
  assign my_mag = my_r[MW-1] ? (~my_r + 1'b1) : my_r;

  // restoring divider step
  assign rem_sh  = {rem_r, nq_r[MW-1]};
  assign q_bit   = (rem_sh >= {1'b0, da_r});
  always_comb begin
    logic [DDW:0] diff;
    diff    = rem_sh - {1'b0, da_r};
    rem_nxt = q_bit ? diff[DDW-1:0] : rem_sh[DDW-1:0];
  end

  // signed quotient, saturated to the coordinate range
  assign q_neg  = (nn_r != dn_r) && (nq_r != '0);
  assign q_clip = (nq_r > QMIN_MAG) ? QMIN_MAG : nq_r;
  assign q_negv = ~q_clip + 1'b1;
  assign res_w  = q_neg ? q_negv[CW-1:0] :
                  ((nq_r > QMAX) ? QMAX[CW-1:0] : nq_r[CW-1:0]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      polycen_pkg::S_IDLE: begin
        if (acc) begin
          if (full) begin
            state_nxt = in_last_vertex ? polycen_pkg::S_FIN : polycen_pkg::S_IDLE;
          end else if (count_r == '0) begin
            state_nxt = in_last_vertex ? polycen_pkg::S_MUL0 : polycen_pkg::S_IDLE;
          end else begin
            state_nxt = polycen_pkg::S_MUL0;
          end
        end
      end
      polycen_pkg::S_MUL0:  state_nxt = polycen_pkg::S_MUL1;
      polycen_pkg::S_MUL1:  state_nxt = polycen_pkg::S_CROSS;
      polycen_pkg::S_CROSS: state_nxt = polycen_pkg::S_MOMX;
      polycen_pkg::S_MOMX:  state_nxt = polycen_pkg::S_MOMY;
      polycen_pkg::S_MOMY:  state_nxt = polycen_pkg::S_ACCY;
      polycen_pkg::S_ACCY: begin
        if (close_r) begin
          state_nxt = polycen_pkg::S_MUL0;
        end else if (last_r) begin
          state_nxt = polycen_pkg::S_FIN;
        end else begin
          state_nxt = polycen_pkg::S_IDLE;
        end
      end
      polycen_pkg::S_FIN: begin
        state_nxt = (ovf_r || d_r == '0) ? polycen_pkg::S_DONE : polycen_pkg::S_DIV;
      end
      polycen_pkg::S_DIV: begin
        if (cnt_r == DIV_LAST) state_nxt = polycen_pkg::S_SAT;
      end
      polycen_pkg::S_SAT: begin
        state_nxt = sel_y_r ? polycen_pkg::S_DONE : polycen_pkg::S_DIV;
      end
      polycen_pkg::S_DONE: begin
        if (out_free) state_nxt = polycen_pkg::S_IDLE;
      end
      default: state_nxt = polycen_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= polycen_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      close_r     <= 1'b0;
      last_r      <= 1'b0;
      sel_y_r     <= 1'b0;
      d_r         <= '0;
      mx_r        <= '0;
      my_r        <= '0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
    end else begin
      state_r <= state_nxt;
      prod_r  <= prod_w;

      if (state_r == polycen_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        polycen_pkg::S_IDLE: begin
          if (acc) begin
            last_r <= in_last_vertex;
            if (full) begin
              ovf_r <= 1'b1;
            end else begin
              count_r  <= count_r + 1'b1;
              prev_x_r <= in_vertex_x;
              prev_y_r <= in_vertex_y;
              ex1_r    <= in_vertex_x;
              ey1_r    <= in_vertex_y;
              if (count_r == '0) begin
                // lone vertex closes on itself: zero cross product
                first_x_r <= in_vertex_x;
                first_y_r <= in_vertex_y;
                ex0_r     <= in_vertex_x;
                ey0_r     <= in_vertex_y;
                close_r   <= 1'b0;
              end else begin
                ex0_r   <= prev_x_r;
                ey0_r   <= prev_y_r;
                close_r <= in_last_vertex;
              end
            end
          end
        end
        polycen_pkg::S_MUL1: pa_r <= prod_r;
        polycen_pkg::S_CROSS: begin
          cross_r <= cross_w;
          d_r     <= d_r + {{(DW-XW){cross_w[XW-1]}}, cross_w};
        end
        polycen_pkg::S_MOMY: mx_r <= mx_r + {{(MW-PW){prod_r[PW-1]}}, prod_r};
        polycen_pkg::S_ACCY: begin
          my_r <= my_r + {{(MW-PW){prod_r[PW-1]}}, prod_r};
          if (close_r) begin
            ex0_r   <= prev_x_r;
            ey0_r   <= prev_y_r;
            ex1_r   <= first_x_r;
            ey1_r   <= first_y_r;
            close_r <= 1'b0;
          end
        end
        polycen_pkg::S_FIN: begin
          cx_r <= '0;
          cy_r <= '0;
          if (ovf_r) begin
            st_r <= polycen_pkg::ST_TOO_MANY;
          end else if (d_r == '0) begin
            st_r <= polycen_pkg::ST_ZERO_AREA;
          end else begin
            st_r    <= polycen_pkg::ST_OK;
            da_r    <= da_w;
            dn_r    <= den_w[DDW-1];
            nq_r    <= mx_mag;
            nn_r    <= mx_r[MW-1];
            rem_r   <= '0;
            cnt_r   <= '0;
            sel_y_r <= 1'b0;
          end
        end
        polycen_pkg::S_DIV: begin
          rem_r <= rem_nxt;
          nq_r  <= {nq_r[MW-2:0], q_bit};
          cnt_r <= cnt_r + 1'b1;
        end
        polycen_pkg::S_SAT: begin
          if (!sel_y_r) begin
            cx_r    <= res_w;
            nq_r    <= my_mag;
            nn_r    <= my_r[MW-1];
            rem_r   <= '0;
            cnt_r   <= '0;
            sel_y_r <= 1'b1;
          end else begin
            cy_r <= res_w;
          end
        end
        polycen_pkg::S_DONE: begin
          if (out_free) begin
            out_cx_r    <= cx_r;
            out_cy_r    <= cy_r;
            out_st_r    <= st_r;
            d_r         <= '0;
            mx_r        <= '0;
            my_r        <= '0;
            count_r     <= '0;
            ovf_r       <= 1'b0;
            last_r      <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/polycen_chk.sv
`default_nettype none

module polycen_chk #(
  parameter int COORD_WIDTH = 16
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   in_last_vertex,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [COORD_WIDTH-1:0] out_centroid_x,
  input wire logic [COORD_WIDTH-1:0] out_centroid_y,
  input wire logic [1:0]             out_status
);

  // a closing beat always leaves work to do
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_vertex |=> in_stall)
    else $error("last vertex accepted without starting work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == polycen_pkg::ST_OK ||
                   out_status == polycen_pkg::ST_ZERO_AREA ||
                   out_status == polycen_pkg::ST_TOO_MANY))
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != polycen_pkg::ST_OK |->
      out_centroid_x == '0 && out_centroid_y == '0)
    else $error("error result carries a centroid");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_centroid_x) &&
      $stable(out_centroid_y) && $stable(out_status))
    else $error("stalled result beat changed");

endmodule

bind polygon_centroid polycen_chk #(.COORD_WIDTH(COORD_WIDTH)) u_polycen_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_last_vertex (in_last_vertex),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_centroid_x (out_centroid_x),
  .out_centroid_y (out_centroid_y),
  .out_status     (out_status)
);

`default_nettype wire
